// File: rtl/u8dec_pkg.sv
// shared types, constants and decode functions for the utf-8 to ucs-2 decoder
`default_nettype none

package u8dec_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned UnitW  = 16;
    localparam int unsigned CountW = 3;
    localparam int unsigned ShiftPerByte = 6;

    // low 16 bits of the per-length marker constants
    localparam logic [UnitW-1:0] MarkLen2    = 16'h3080;
    localparam logic [UnitW-1:0] MarkLenLong = 16'h2080;

    // lead-byte thresholds
    localparam logic [ByteW-1:0] Lead2Min = 8'hC0;
    localparam logic [ByteW-1:0] Lead3Min = 8'hE0;
    localparam logic [ByteW-1:0] Lead4Min = 8'hF0;
    localparam logic [ByteW-1:0] Lead5Min = 8'hF8;
    localparam logic [ByteW-1:0] Lead6Min = 8'hFC;

    localparam logic [CountW-1:0] LenIdle = 3'd0;
    localparam logic [CountW-1:0] LenOne  = 3'd1;
    localparam logic [CountW-1:0] LenTwo  = 3'd2;
    localparam logic [CountW-1:0] LenSix  = 3'd6;

    typedef struct packed {
        logic [UnitW-1:0]  acc;
        logic [CountW-1:0] bytes_left;
        logic [CountW-1:0] seq_len;
    } dec_state_t;

    typedef struct packed {
        logic              emit;
        logic [UnitW-1:0]  code_unit;
        logic              last_unit;
        logic              truncated;
    } dec_result_t;

    function automatic logic [CountW-1:0] lead_length(input logic [ByteW-1:0] b);
        logic [CountW-1:0] len;
        if (b < Lead2Min) begin
            len = 3'd1;
        end else if (b < Lead3Min) begin
            len = 3'd2;
        end else if (b < Lead4Min) begin
            len = 3'd3;
        end else if (b < Lead5Min) begin
            len = 3'd4;
        end else if (b < Lead6Min) begin
            len = 3'd5;
        end else begin
            len = 3'd6;
        end
        return len;
    endfunction

    function automatic logic [UnitW-1:0] length_marker(input logic [CountW-1:0] len);
        logic [UnitW-1:0] mark;
        unique case (len)
            3'd2:                      mark = MarkLen2;
            3'd3, 3'd4, 3'd5, 3'd6:    mark = MarkLenLong;
            default:                   mark = '0;
        endcase
        return mark;
    endfunction

endpackage

`default_nettype wire

// File: rtl/u8dec_step.sv
// one decode step: folds a byte into the sequence state and forms the result
`default_nettype none

module u8dec_step
    import u8dec_pkg::*;
(
    input  wire logic [ByteW-1:0] data_byte,
    input  wire logic             frame_end,
    input  wire dec_state_t       state_cur,
    output dec_state_t            state_next,
    output dec_result_t           result
);

    logic [UnitW-1:0]  acc_new;
    logic [CountW-1:0] left_new;
    logic [CountW-1:0] len_new;

    always_comb begin
        if (state_cur.bytes_left == '0) begin
            // lead byte opens a new sequence
            len_new  = lead_length(data_byte);
            left_new = len_new - LenOne;
            acc_new  = {{(UnitW-ByteW){1'b0}}, data_byte};
        end else begin
            len_new  = state_cur.seq_len;
            left_new = state_cur.bytes_left - LenOne;
            acc_new  = (state_cur.acc << ShiftPerByte) + {{(UnitW-ByteW){1'b0}}, data_byte};
        end
    end

    always_comb begin
        state_next = '0;
        result     = '0;
        if (left_new == '0) begin
            result.emit      = 1'b1;
            result.code_unit = acc_new - length_marker(len_new);
            result.last_unit = frame_end;
        end else if (frame_end) begin
            // partial sequence dropped at frame end
            result.emit      = 1'b1;
            result.last_unit = 1'b1;
            result.truncated = 1'b1;
        end else begin
            state_next.acc        = acc_new;
            state_next.bytes_left = left_new;
            state_next.seq_len    = len_new;
        end
    end

endmodule

`default_nettype wire

// File: rtl/utf8_to_ucs2_decoder.sv
// top level of the utf-8 to ucs-2 decoder: sequence state and result register
`default_nettype none

//  channel  | direction | ports                                          | moves
//  ---------+-----------+------------------------------------------------+---------------------
//  s_       | in        | s_valid s_ready s_data_byte s_frame_end        | one byte request
//  m_       | out       | m_valid m_ready m_code_unit m_last_unit        | one code unit result
//           |           | m_truncated                                    |
//
//  one request is taken per cycle while s_ready is high; a result appears in the cycle after
//  the byte that ends a sequence (or ends the frame inside one), set by the single result register
//  bytes in the middle of a sequence give no result and only update the state registers
//  reset (aresetn low, synchronous) empties the result register and returns to idle
//  s_ready is low only while a held result is stalled by m_ready

module utf8_to_ucs2_decoder
    import u8dec_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [ByteW-1:0] s_data_byte,
    input  wire logic             s_frame_end,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [UnitW-1:0]      m_code_unit,
    output logic                  m_last_unit,
    output logic                  m_truncated
);

    dec_state_t       state_reg, state_next, step_state;
    dec_result_t      step_result;
    logic             m_valid_reg, m_valid_next;
    logic [UnitW-1:0] code_unit_reg, code_unit_next;
    logic             last_unit_reg, last_unit_next;
    logic             truncated_reg, truncated_next;
    logic             s_fire;

    // the result register frees up in the same cycle it is taken
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    u8dec_step u_step (
        .data_byte  (s_data_byte),
        .frame_end  (s_frame_end),
        .state_cur  (state_reg),
        .state_next (step_state),
        .result     (step_result)
    );

    always_comb begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        code_unit_next = code_unit_reg;
        last_unit_next = last_unit_reg;
        truncated_next = truncated_reg;
        if (s_fire) begin
            state_next = step_state;
            if (step_result.emit) begin
                m_valid_next   = 1'b1;
                code_unit_next = step_result.code_unit;
                last_unit_next = step_result.last_unit;
                truncated_next = step_result.truncated;
            end
        end
    end

    // control state cleared on reset, result payload needs none
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        code_unit_reg <= code_unit_next;
        last_unit_reg <= last_unit_next;
        truncated_reg <= truncated_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_code_unit = code_unit_reg;
    assign m_last_unit = last_unit_reg;
    assign m_truncated = truncated_reg;

    // an open sequence always has a multi-byte length and fewer bytes left than its length
    a_open_seq_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.bytes_left != '0 |->
            (state_reg.seq_len >= LenTwo && state_reg.seq_len <= LenSix
             && state_reg.bytes_left < state_reg.seq_len))
        else $error("open sequence with inconsistent length");

    // idle state carries no partial character
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.bytes_left == '0 |-> (state_reg.acc == '0 && state_reg.seq_len == LenIdle))
        else $error("idle state holds stale accumulator");

    // a frame-end byte always produces a result and leaves the block idle
    a_frame_end_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_frame_end |=> (m_valid && m_last_unit && state_reg.bytes_left == '0))
        else $error("frame end did not close the frame");

    // a dropped sequence reports a zero code unit on the frame's last result
    a_trunc_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_truncated |-> (m_last_unit && m_code_unit == '0))
        else $error("truncation result malformed");

endmodule

`default_nettype wire
